// ===== rtl/qvw_pkg.sv =====
package qvw_pkg;

   // coordinate format: signed Q11.8 at the default width
   localparam int COORD_W = 20;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int NORM_W  = 15;
   localparam int SH_W    = $clog2(DIFF_W + 1);
   localparam int HW_W    = 16;
   localparam int RATIO_W = HW_W;
   localparam int SQ_W    = 2 * NORM_W;
   localparam int LEN2_W  = SQ_W + 1;
   localparam int HW2_W   = 2 * HW_W;
   localparam int RHS_W   = SQ_W + HW2_W;
   localparam int ACC_W   = 2 * RATIO_W + LEN2_W;
   localparam int PROD_W  = RATIO_W + LEN2_W;
   localparam int OFF_W   = RATIO_W + 1;
   localparam int V_W     = ((COORD_W > OFF_W) ? COORD_W : OFF_W) + 1;
   localparam int N_W     = V_W + 1;
   localparam int MUL_W   = N_W + V_W;
   localparam int DOT_W   = MUL_W + 1;
   localparam int N_VERT  = 4;
   localparam int N_AXES  = 2 * N_VERT;

   localparam logic [HW_W-1:0] HW_RESET = HW_W'(256);

   // pipeline stage map
   localparam int ST_IN       = 0;
   localparam int ST_DIFF     = 1;
   localparam int ST_RATIO    = 5;
   localparam int ST_RECT     = ST_RATIO + RATIO_W;
   localparam int ST_AXIS     = ST_RECT + 1;
   localparam int ST_LANE     = ST_AXIS + 1;
   localparam int LANE_STAGES = 4;
   localparam int ST_OUT      = ST_LANE + LANE_STAGES;
   localparam int NST         = ST_OUT + 1;
   localparam int OFF_STAGES  = ST_RECT - ST_DIFF;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [V_W-1:0]     vcoord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } cpt_type;

   typedef struct packed {
      cpt_type [N_VERT-1:0] quad;
      cpt_type              s;
      cpt_type              e;
   } ctx_type;

   typedef struct packed {
      vcoord_type x;
      vcoord_type y;
   } vpt_type;

   typedef struct packed {
      logic signed [N_W-1:0] nx;
      logic signed [N_W-1:0] ny;
   } axis_type;

   typedef struct packed {
      logic deg;
      logic dx_pos;
      logic dy_neg;
   } flags_type;

endpackage

// ===== rtl/qvw_ratio.sv =====
module qvw_ratio
   import qvw_pkg::*;
(
   input  logic               clock,
   input  logic [RATIO_W-1:0] en,
   input  logic [LEN2_W-1:0]  len2,
   input  logic [RHS_W-1:0]   rhs,
   output logic [RATIO_W-1:0] q
);

   // one result bit per stage, msb first: largest t with t*t*len2 <= rhs
   logic [RATIO_W-1:0] t_ff    [RATIO_W];
   logic [ACC_W-1:0]   acc_ff  [RATIO_W];
   logic [PROD_W-1:0]  prod_ff [RATIO_W];
   logic [LEN2_W-1:0]  len2_ff [RATIO_W];
   logic [RHS_W-1:0]   rhs_ff  [RATIO_W];

   genvar i;
   generate
      for (i = 0; i < RATIO_W; i++) begin : g_step
         localparam int B = RATIO_W - 1 - i;
         logic [RATIO_W-1:0] t_prev;
         logic [ACC_W-1:0]   acc_prev;
         logic [PROD_W-1:0]  prod_prev;
         logic [LEN2_W-1:0]  len2_prev;
         logic [RHS_W-1:0]   rhs_prev;
         logic [ACC_W-1:0]   cand;
         logic               take;

         if (i == 0) begin : g_first
            assign t_prev    = '0;
            assign acc_prev  = '0;
            assign prod_prev = '0;
            assign len2_prev = len2;
            assign rhs_prev  = rhs;
         end else begin : g_next
            assign t_prev    = t_ff[i-1];
            assign acc_prev  = acc_ff[i-1];
            assign prod_prev = prod_ff[i-1];
            assign len2_prev = len2_ff[i-1];
            assign rhs_prev  = rhs_ff[i-1];
         end

         // (t + 2^B)^2 * len2 = acc + t*len2*2^(B+1) + len2*2^(2B)
         assign cand = acc_prev + (ACC_W'(prod_prev) << (B + 1))
                       + (ACC_W'(len2_prev) << (2 * B));
         assign take = (cand <= ACC_W'(rhs_prev));

         always_ff @(posedge clock) begin
            if (en[i]) begin
               len2_ff[i] <= len2_prev;
               rhs_ff[i]  <= rhs_prev;
               if (take) begin
                  t_ff[i]    <= t_prev | (RATIO_W'(1) << B);
                  acc_ff[i]  <= cand;
                  prod_ff[i] <= prod_prev + (PROD_W'(len2_prev) << B);
               end else begin
                  t_ff[i]    <= t_prev;
                  acc_ff[i]  <= acc_prev;
                  prod_ff[i] <= prod_prev;
               end
            end
         end
      end
   endgenerate

   assign q = t_ff[RATIO_W-1];

endmodule

// ===== rtl/qvw_offset.sv =====
module qvw_offset
   import qvw_pkg::*;
(
   input  logic                  clock,
   input  logic [OFF_STAGES-1:0] en,
   input  cpt_type               seg_s,
   input  cpt_type               seg_e,
   input  logic [HW_W-1:0]       hw,
   output logic [RATIO_W-1:0]    mx,
   output logic [RATIO_W-1:0]    my,
   output flags_type             flags
);

   logic signed [DIFF_W-1:0] dx, dy;
   logic [DIFF_W-1:0]        ux, uy, mag_or;
   logic [SH_W-1:0]          sh;

   logic [DIFF_W-1:0] ux_ff, uy_ff;
   logic [HW_W-1:0]   hw1_ff, hw2s_ff;
   logic [NORM_W-1:0] unx_ff, uny_ff;
   logic [SQ_W-1:0]   ux2_ff, uy2_ff;
   logic [HW2_W-1:0]  hwsq_ff;
   logic [LEN2_W-1:0] len2_ff;
   logic [RHS_W-1:0]  rhsx_ff, rhsy_ff;
   flags_type         flag_ff [OFF_STAGES];
   flags_type         flag_in;

   assign dx = DIFF_W'(seg_e.x) - DIFF_W'(seg_s.x);
   assign dy = DIFF_W'(seg_e.y) - DIFF_W'(seg_s.y);

   always_comb begin
      flag_in.deg    = (dx == '0) && (dy == '0);
      flag_in.dx_pos = !dx[DIFF_W-1] && (dx != '0);
      flag_in.dy_neg = dy[DIFF_W-1];
      ux = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      uy = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
   end

   // shift right until both magnitudes fit in NORM_W bits
   assign mag_or = ux_ff | uy_ff;
   always_comb begin
      sh = '0;
      for (int k = 0; k < DIFF_W; k++) begin
         if (k >= NORM_W && mag_or[k]) begin
            sh = SH_W'(k - NORM_W + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ux_ff  <= ux;
         uy_ff  <= uy;
         hw1_ff <= hw;
      end
      if (en[1]) begin
         unx_ff  <= NORM_W'(ux_ff >> sh);
         uny_ff  <= NORM_W'(uy_ff >> sh);
         hw2s_ff <= hw1_ff;
      end
      if (en[2]) begin
         ux2_ff  <= SQ_W'(unx_ff) * SQ_W'(unx_ff);
         uy2_ff  <= SQ_W'(uny_ff) * SQ_W'(uny_ff);
         hwsq_ff <= HW2_W'(hw2s_ff) * HW2_W'(hw2s_ff);
      end
      if (en[3]) begin
         len2_ff <= LEN2_W'(ux2_ff) + LEN2_W'(uy2_ff);
         rhsx_ff <= RHS_W'(ux2_ff) * RHS_W'(hwsq_ff);
         rhsy_ff <= RHS_W'(uy2_ff) * RHS_W'(hwsq_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < OFF_STAGES; j++) begin
         if (en[j]) begin
            flag_ff[j] <= (j == 0) ? flag_in : flag_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   qvw_ratio u_ratio_x (
      .clock (clock),
      .en    (en[OFF_STAGES-1:ST_RATIO-ST_DIFF]),
      .len2  (len2_ff),
      .rhs   (rhsx_ff),
      .q     (mx)
   );

   qvw_ratio u_ratio_y (
      .clock (clock),
      .en    (en[OFF_STAGES-1:ST_RATIO-ST_DIFF]),
      .len2  (len2_ff),
      .rhs   (rhsy_ff),
      .q     (my)
   );

   assign flags = flag_ff[OFF_STAGES-1];

endmodule

// ===== rtl/qvw_lane.sv =====
module qvw_lane
   import qvw_pkg::*;
(
   input  logic                   clock,
   input  logic [LANE_STAGES-1:0] en,
   input  axis_type               axis,
   input  vpt_type [N_VERT-1:0]   qv,
   input  vpt_type [N_VERT-1:0]   rv,
   output logic                   sep
);

   typedef logic signed [DOT_W-1:0] dot_type;

   logic signed [MUL_W-1:0] px_ff [N_AXES];
   logic signed [MUL_W-1:0] py_ff [N_AXES];
   dot_type                 dot_ff [N_AXES];
   dot_type                 min_a_ff, max_a_ff, min_b_ff, max_b_ff;
   logic                    sep_ff;
   vpt_type                 vall [N_AXES];

   function automatic dot_type min2(input dot_type a, input dot_type b);
      return (b < a) ? b : a;
   endfunction

   function automatic dot_type max2(input dot_type a, input dot_type b);
      return (a < b) ? b : a;
   endfunction

   always_comb begin
      for (int k = 0; k < N_VERT; k++) begin
         vall[k]          = qv[k];
         vall[k + N_VERT] = rv[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N_AXES; k++) begin
         if (en[0]) begin
            px_ff[k] <= MUL_W'(axis.nx) * MUL_W'(vall[k].x);
            py_ff[k] <= MUL_W'(axis.ny) * MUL_W'(vall[k].y);
         end
         if (en[1]) begin
            dot_ff[k] <= DOT_W'(px_ff[k]) + DOT_W'(py_ff[k]);
         end
      end
      if (en[2]) begin
         min_a_ff <= min2(min2(dot_ff[0], dot_ff[1]), min2(dot_ff[2], dot_ff[3]));
         max_a_ff <= max2(max2(dot_ff[0], dot_ff[1]), max2(dot_ff[2], dot_ff[3]));
         min_b_ff <= min2(min2(dot_ff[4], dot_ff[5]), min2(dot_ff[6], dot_ff[7]));
         max_b_ff <= max2(max2(dot_ff[4], dot_ff[5]), max2(dot_ff[6], dot_ff[7]));
      end
      // touching intervals do not separate
      if (en[3]) begin
         sep_ff <= (max_a_ff < min_b_ff) || (max_b_ff < min_a_ff);
      end
   end

   assign sep = sep_ff;

endmodule

// ===== rtl/quad_vs_wide_segment_overlap_unit.sv =====
// channel   | ports                              | moves
// ----------+------------------------------------+------------------------------------
// request   | req_valid/req_ready, req_*         | quad corners and segment endpoints
// response  | rsp_valid/rsp_ready, rsp_*         | overlap and degenerate flags
// csr       | csr_wr_en, csr_wr_data             | half width, written at once
//
// One request per cycle enters while req_ready is high; rsp_valid rises when it
// has passed the 28 register stages from request to response.
// The 16-step reciprocal-root divide pipeline dominates the depth.
// A stage advances when it or any stage after it holds a bubble, or the response is taken.
// Reset clears the valid bits and loads half width with 256 (1.0).
module quad_vs_wide_segment_overlap_unit
   import qvw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  coord_type         req_quad_x0,
   input  coord_type         req_quad_y0,
   input  coord_type         req_quad_x1,
   input  coord_type         req_quad_y1,
   input  coord_type         req_quad_x2,
   input  coord_type         req_quad_y2,
   input  coord_type         req_quad_x3,
   input  coord_type         req_quad_y3,
   input  coord_type         req_seg_start_x,
   input  coord_type         req_seg_start_y,
   input  coord_type         req_seg_end_x,
   input  coord_type         req_seg_end_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_overlap,
   output logic              rsp_degenerate,
   input  logic              csr_wr_en,
   input  logic [HW_W-1:0]   csr_wr_data
);

   logic [NST-1:0]    v_ff;
   logic [NST-1:0]    en;
   logic [HW_W-1:0]   hw_ff, hw0_ff;
   ctx_type           ctx_ff [ST_RECT];
   ctx_type           ctx_in;
   logic [RATIO_W-1:0] mx, my;
   flags_type         flags;
   logic signed [OFF_W-1:0] tx, ty;
   vpt_type [N_VERT-1:0] qv_ff, rv_ff, qv2_ff, rv2_ff;
   vpt_type [N_VERT-1:0] rv_in;
   axis_type          axis_ff [N_AXES];
   logic              deg_ff [ST_RECT:ST_OUT-1];
   logic [N_AXES-1:0] sep;
   logic              overlap_ff, degen_ff;

   // stage k moves when it or any later stage is empty or the response leaves
   genvar k;
   generate
      for (k = 0; k < NST; k++) begin : g_en
         assign en[k] = ~((&v_ff[NST-1:k]) & ~rsp_ready);
      end
   endgenerate

   assign req_ready = en[ST_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         hw_ff <= HW_RESET;
      end else begin
         if (csr_wr_en) begin
            hw_ff <= csr_wr_data;
         end
         for (int s = 0; s < NST; s++) begin
            if (en[s]) begin
               v_ff[s] <= (s == 0) ? req_valid : v_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end
   end

   always_comb begin
      ctx_in.quad[0] = '{x: req_quad_x0, y: req_quad_y0};
      ctx_in.quad[1] = '{x: req_quad_x1, y: req_quad_y1};
      ctx_in.quad[2] = '{x: req_quad_x2, y: req_quad_y2};
      ctx_in.quad[3] = '{x: req_quad_x3, y: req_quad_y3};
      ctx_in.s       = '{x: req_seg_start_x, y: req_seg_start_y};
      ctx_in.e       = '{x: req_seg_end_x, y: req_seg_end_y};
   end

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         hw0_ff <= hw_ff;
      end
      for (int s = 0; s < ST_RECT; s++) begin
         if (en[s]) begin
            ctx_ff[s] <= (s == 0) ? ctx_in : ctx_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   qvw_offset u_offset (
      .clock (clock),
      .en    (en[ST_RECT-1:ST_DIFF]),
      .seg_s (ctx_ff[ST_IN].s),
      .seg_e (ctx_ff[ST_IN].e),
      .hw    (hw0_ff),
      .mx    (mx),
      .my    (my),
      .flags (flags)
   );

   // offset points along the perpendicular (dy, -dx)
   always_comb begin
      tx = flags.dy_neg ? -OFF_W'(my) : OFF_W'(my);
      ty = flags.dx_pos ? -OFF_W'(mx) : OFF_W'(mx);
      rv_in[0].x = V_W'(ctx_ff[ST_RECT-1].s.x) + V_W'(tx);
      rv_in[0].y = V_W'(ctx_ff[ST_RECT-1].s.y) + V_W'(ty);
      rv_in[1].x = V_W'(ctx_ff[ST_RECT-1].e.x) + V_W'(tx);
      rv_in[1].y = V_W'(ctx_ff[ST_RECT-1].e.y) + V_W'(ty);
      rv_in[2].x = V_W'(ctx_ff[ST_RECT-1].e.x) - V_W'(tx);
      rv_in[2].y = V_W'(ctx_ff[ST_RECT-1].e.y) - V_W'(ty);
      rv_in[3].x = V_W'(ctx_ff[ST_RECT-1].s.x) - V_W'(tx);
      rv_in[3].y = V_W'(ctx_ff[ST_RECT-1].s.y) - V_W'(ty);
   end

   always_ff @(posedge clock) begin
      if (en[ST_RECT]) begin
         rv_ff <= rv_in;
         for (int i = 0; i < N_VERT; i++) begin
            qv_ff[i].x <= V_W'(ctx_ff[ST_RECT-1].quad[i].x);
            qv_ff[i].y <= V_W'(ctx_ff[ST_RECT-1].quad[i].y);
         end
      end
      if (en[ST_AXIS]) begin
         qv2_ff <= qv_ff;
         rv2_ff <= rv_ff;
         for (int i = 0; i < N_VERT; i++) begin
            axis_ff[i].nx <= N_W'(qv_ff[(i + 1) % N_VERT].y) - N_W'(qv_ff[i].y);
            axis_ff[i].ny <= N_W'(qv_ff[i].x) - N_W'(qv_ff[(i + 1) % N_VERT].x);
            axis_ff[i + N_VERT].nx <= N_W'(rv_ff[(i + 1) % N_VERT].y) - N_W'(rv_ff[i].y);
            axis_ff[i + N_VERT].ny <= N_W'(rv_ff[i].x) - N_W'(rv_ff[(i + 1) % N_VERT].x);
         end
      end
      for (int s = ST_RECT; s < ST_OUT; s++) begin
         if (en[s]) begin
            deg_ff[s] <= (s == ST_RECT) ? flags.deg : deg_ff[(s == ST_RECT) ? ST_RECT : s - 1];
         end
      end
      if (en[ST_OUT]) begin
         overlap_ff <= !deg_ff[ST_OUT-1] && (sep == '0);
         degen_ff   <= deg_ff[ST_OUT-1];
      end
   end

   generate
      for (k = 0; k < N_AXES; k++) begin : g_lane
         qvw_lane u_lane (
            .clock (clock),
            .en    (en[ST_OUT-1:ST_LANE]),
            .axis  (axis_ff[k]),
            .qv    (qv2_ff),
            .rv    (rv2_ff),
            .sep   (sep[k])
         );
      end
   endgenerate

   assign rsp_valid      = v_ff[ST_OUT];
   assign rsp_overlap    = overlap_ff;
   assign rsp_degenerate = degen_ff;

`ifndef ASSERT_OFF
   a_deg_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overlap && rsp_degenerate))
      else $error("degenerate response reports overlap");

   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (v_ff[ST_OUT-1] && en[ST_OUT]) |=> rsp_valid)
      else $error("request lost entering the output stage");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff))
      else $error("request refused while a bubble remains");
`endif

endmodule

// ===== tb/tb_quad_vs_wide_segment_overlap_unit.sv =====
module tb_quad_vs_wide_segment_overlap_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import qvw_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] qx[4];
      logic signed [COORD_W-1:0] qy[4];
      logic signed [COORD_W-1:0] sx, sy, ex, ey;
   } test_type;

   typedef struct {
      logic overlap;
      logic degenerate;
   } verdict_type;

   int error_count = 0;

   task automatic report(input string what, input logic got, input logic want);
      $display("mismatch %s: got %0b want %0b at %0t", what, got, want, $time);
      error_count++;
   endtask

   class overlap_scoreboard;
      logic [HW_W-1:0] hw = HW_RESET;
      verdict_type pending[$];

      // floor(hw*num/sqrt(len2)) by bitwise search
      function automatic longint ratio(longint num, longint len2);
         longint rhs, t, c;
         rhs = num * num * longint'(hw) * longint'(hw);
         t = 0;
         for (int b = 15; b >= 0; b--) begin
            c = t | (64'sd1 << b);
            if (c * c * len2 <= rhs) t = c;
         end
         return t;
      endfunction

      function automatic void span(input longint px[4], input longint py[4],
                                   input longint nx, input longint ny,
                                   output longint lo, output longint hi);
         longint p;
         for (int k = 0; k < 4; k++) begin
            p = nx * px[k] + ny * py[k];
            if (k == 0 || p < lo) lo = p;
            if (k == 0 || p > hi) hi = p;
         end
      endfunction

      function automatic verdict_type predict(test_type t);
         verdict_type v;
         longint ax[4], ay[4], bx[4], by[4], px[4], py[4];
         longint dx, dy, ux, uy, len2, tx, ty, nx, ny, la, ha, lb, hb;
         int j;
         for (int k = 0; k < 4; k++) begin
            ax[k] = t.qx[k];
            ay[k] = t.qy[k];
         end
         dx = longint'(t.ex) - longint'(t.sx);
         dy = longint'(t.ey) - longint'(t.sy);
         v.degenerate = (dx == 0 && dy == 0);
         v.overlap = 0;
         if (v.degenerate) return v;
         ux = dx < 0 ? -dx : dx;
         uy = dy < 0 ? -dy : dy;
         while ((ux | uy) >= (64'sd1 << 15)) begin
            ux >>= 1;
            uy >>= 1;
         end
         len2 = ux * ux + uy * uy;
         tx = ratio(uy, len2);
         ty = ratio(ux, len2);
         if (dy < 0) tx = -tx;
         if (dx > 0) ty = -ty;
         bx[0] = t.sx + tx; by[0] = t.sy + ty;
         bx[1] = t.ex + tx; by[1] = t.ey + ty;
         bx[2] = t.ex - tx; by[2] = t.ey - ty;
         bx[3] = t.sx - tx; by[3] = t.sy - ty;
         v.overlap = 1;
         for (int poly = 0; poly < 2; poly++) begin
            for (int k = 0; k < 4; k++) begin
               if (poly == 0) begin
                  px[k] = ax[k];
                  py[k] = ay[k];
               end else begin
                  px[k] = bx[k];
                  py[k] = by[k];
               end
            end
            for (int i = 0; i < 4; i++) begin
               j = (i + 1) & 3;
               nx = py[j] - py[i];
               ny = px[i] - px[j];
               span(ax, ay, nx, ny, la, ha);
               span(bx, by, nx, ny, lb, hb);
               if (ha < lb || hb < la) v.overlap = 0;
            end
         end
         return v;
      endfunction

      function void note_request(test_type t);
         pending = {pending, predict(t)};
      endfunction

      task check_response(logic overlap, logic degenerate);
         verdict_type w;
         if (pending.size() == 0) begin
            report("unexpected response", 1'b1, 1'b0);
            return;
         end
         w = pending.pop_front();
         if (overlap !== w.overlap) report("overlap", overlap, w.overlap);
         if (degenerate !== w.degenerate) report("degenerate", degenerate, w.degenerate);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0, rsp_overlap, rsp_degenerate;
   coord_type qx[4], qy[4], sx, sy, ex, ey;
   logic csr_wr_en = 0;
   logic [HW_W-1:0] csr_wr_data = '0;
   int send_idle = 0, recv_stall = 0;
   bit hold_off = 0;
   longint cycles = 0;
   overlap_scoreboard sb = new();

   initial begin
      for (int k = 0; k < 4; k++) begin
         qx[k] = '0;
         qy[k] = '0;
      end
      {sx, sy, ex, ey} = '0;
   end

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   quad_vs_wide_segment_overlap_unit dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_quad_x0(qx[0]), .req_quad_y0(qy[0]), .req_quad_x1(qx[1]), .req_quad_y1(qy[1]),
      .req_quad_x2(qx[2]), .req_quad_y2(qy[2]), .req_quad_x3(qx[3]), .req_quad_y3(qy[3]),
      .req_seg_start_x(sx), .req_seg_start_y(sy), .req_seg_end_x(ex), .req_seg_end_y(ey),
      .rsp_valid, .rsp_ready, .rsp_overlap, .rsp_degenerate, .csr_wr_en, .csr_wr_data);

   always @(posedge clock) begin
      test_type t;
      cycles++;
      if (cycles > 2000000) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && req_valid && req_ready) begin
         for (int k = 0; k < 4; k++) begin
            t.qx[k] = qx[k];
            t.qy[k] = qy[k];
         end
         t.sx = sx; t.sy = sy; t.ex = ex; t.ey = ey;
         sb.note_request(t);
      end
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_overlap, rsp_degenerate);
   end

   // receiver: random stall, or a long hold-off when asked
   always @(negedge clock)
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall);

   // valid stays up between back-to-back requests; drop it only while idle
   task automatic send(test_type t);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      for (int k = 0; k < 4; k++) begin
         qx[k] <= t.qx[k];
         qy[k] <= t.qy[k];
      end
      sx <= t.sx; sy <= t.sy; ex <= t.ex; ey <= t.ey;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic coord_type pick(int scale);
      case ($urandom_range(9))
         0: return {1'b1, {(COORD_W-1){1'b0}}};
         1: return {1'b0, {(COORD_W-1){1'b1}}};
         default: return coord_type'($signed($urandom) >>> (32 - scale));
      endcase
   endfunction

   // well-formed convex quad most of the time, noise otherwise
   function automatic test_type make_test();
      test_type t;
      int sc, cx, cy, w, h;
      sc = $urandom_range(3) == 0 ? COORD_W : $urandom_range(16, 8);
      if ($urandom_range(4) == 0) begin
         for (int k = 0; k < 4; k++) begin
            t.qx[k] = pick(sc);
            t.qy[k] = pick(sc);
         end
      end else begin
         cx = $signed($urandom) >>> (33 - sc);
         cy = $signed($urandom) >>> (33 - sc);
         w = $urandom_range(1 << (sc - 3));
         h = $urandom_range(1 << (sc - 3));
         t.qx[0] = cx - w; t.qy[0] = cy - h;
         t.qx[1] = cx + w; t.qy[1] = cy - h;
         t.qx[2] = cx + w; t.qy[2] = cy + h;
         t.qx[3] = cx - w; t.qy[3] = cy + h;
         if ($urandom_range(3) == 0) t.qx[2] = t.qx[1];
      end
      t.sx = pick(sc);
      t.sy = pick(sc);
      case ($urandom_range(9))
         0: begin t.ex = t.sx; t.ey = t.sy; end
         1: begin t.ex = t.sx; t.ey = pick(sc); end
         2: begin t.ex = pick(sc); t.ey = t.sy; end
         default: begin t.ex = pick(sc); t.ey = pick(sc); end
      endcase
      return t;
   endfunction

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_half_width(logic [HW_W-1:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      sb.hw = v;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic directed();
      test_type t;
      coord_type lo, hi;
      lo = {1'b1, {(COORD_W-1){1'b0}}};
      hi = {1'b0, {(COORD_W-1){1'b1}}};
      for (int k = 0; k < 4; k++) begin
         t.qx[k] = (k == 1 || k == 2) ? 256 : -256;
         t.qy[k] = (k >= 2) ? 256 : -256;
      end
      t.sx = 0; t.sy = 0; t.ex = 0; t.ey = 0; send(t);        // zero-length segment
      t.sx = -1024; t.ex = 1024; send(t);                       // crossing
      t.sy = 512; t.ey = 512; send(t);                          // touching with width 1.0
      t.sy = 513; t.ey = 513; send(t);                          // just clear
      t.sx = 2000; t.sy = 2000; t.ex = 3000; t.ey = 2900; send(t);
      t.sx = lo; t.sy = lo; t.ex = hi; t.ey = hi; send(t);      // full-range diagonal
      t.sx = hi; t.sy = lo; t.ex = lo; t.ey = hi; send(t);
      t.sx = lo; t.sy = 0; t.ex = hi; t.ey = 0; send(t);
      t.sx = 0; t.sy = hi; t.ex = 0; t.ey = lo; send(t);
      for (int k = 0; k < 4; k++) begin
         t.qx[k] = k[0] ? hi : lo;
         t.qy[k] = k[1] ? hi : lo;
      end
      send(t);                                                  // misordered, extreme corners
      for (int k = 0; k < 4; k++) begin
         t.qx[k] = 100;
         t.qy[k] = 100;
      end
      t.sx = 0; t.sy = 0; t.ex = 300; t.ey = 300; send(t);      // collapsed quad edges
      t.sx = -5; t.sy = 7; t.ex = -4; t.ey = 7; send(t);        // unit-length segment
   endtask

   initial begin
      int idle_cfg[4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{12, 12}};
      logic [HW_W-1:0] widths[6] = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd4096, 16'd77};
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      directed();
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_half_width(ph == 5 ? 16'($urandom) : widths[ph]);
         directed();
         for (int p = 0; p < 4; p++) begin
            send_idle = idle_cfg[p][0];
            recv_stall = idle_cfg[p][1];
            repeat (50) send(make_test());
         end
         drain();
      end
      // hold the receiver off while requests keep coming so the pipeline backs up
      send_idle = 0;
      recv_stall = 0;
      fork
         begin
            hold_off = 1;
            for (int c = 0; c < 200; c++) @(negedge clock);
            hold_off = 0;
         end
         repeat (60) send(make_test());
      join
      drain();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/qvw_pkg.sv
rtl/qvw_ratio.sv
rtl/qvw_offset.sv
rtl/qvw_lane.sv
rtl/quad_vs_wide_segment_overlap_unit.sv
tb/tb_quad_vs_wide_segment_overlap_unit.sv
